### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the framed packet encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define CFPE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfpe assertion failed");
// Condition must never be true outside reset
`define CFPE_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cfpe forbidden condition seen");
`else
`define CFPE_ASSERT(lbl, clk, rst_n, prop)
`define CFPE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hdl/cfpe_pkg.sv
// ----------------------------------------------------------------------------
// cfpe_pkg
// Types, constants and CRC helper for the CRC-32 framed packet encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpe_pkg;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Reset value of the maximum payload register
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Byte positions within one frame as seen by the back end
    localparam logic [3:0] IDX_MAGIC0 = 4'd0;
    localparam logic [3:0] IDX_MAGIC3 = 4'd3;
    localparam logic [3:0] IDX_CHAN   = 4'd4;
    localparam logic [3:0] IDX_SEQ0   = 4'd5;
    localparam logic [3:0] IDX_SEQ1   = 4'd6;
    localparam logic [3:0] IDX_SEQ2   = 4'd7;
    localparam logic [3:0] IDX_SEQ3   = 4'd8;
    localparam logic [3:0] IDX_LEN0   = 4'd9;
    localparam logic [3:0] IDX_LEN1   = 4'd10;
    localparam logic [3:0] IDX_DATA   = 4'd11;
    localparam logic [3:0] IDX_CRC0   = 4'd12;
    localparam logic [3:0] IDX_CRC1   = 4'd13;
    localparam logic [3:0] IDX_CRC2   = 4'd14;
    localparam logic [3:0] IDX_CRC3   = 4'd15;

    // Kind of work handed from front to back
    typedef enum logic [1:0] {
        CMD_ERR   = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic [7:0]  chan;
        logic [31:0] seq;
        logic [15:0] len;
        logic        last;   // this payload byte closes the frame
    } cmd_t;

    // Magic bytes "VID1"
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h56;
            2'd1:    b = 8'h49;
            2'd2:    b = 8'h44;
            2'd3:    b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/cfpe_front.sv
// ----------------------------------------------------------------------------
// cfpe_front
// Accepts input items, checks frame headers and tracks the open frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpe_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic [7:0]    channel,
    input  wire logic [31:0]   sequence_req,
    input  wire logic [15:0]   length,
    input  wire logic          q_full,
    output logic               q_push,
    output cfpe_pkg::cmd_t     q_cmd
);
    import cfpe_pkg::*;

    logic [15:0] max_payload_reg;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic        refuse;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Header check, only meaningful between frames
    assign refuse = (length == 16'd0) || (length > max_payload_reg) ||
                    (channel == 8'd0) || (channel > 8'd3);

    // Classify the item
    always_comb
    begin
        q_cmd.data      = data_byte;
        q_cmd.chan      = channel;
        q_cmd.seq       = sequence_req;
        q_cmd.len       = length;
        bytes_left_next = bytes_left_reg;
        if (bytes_left_reg == 16'd0)
        begin
            if (refuse)
            begin
                q_cmd.kind = CMD_ERR;
                q_cmd.last = 1'b0;
            end
            else
            begin
                q_cmd.kind      = CMD_START;
                q_cmd.last      = (length == 16'd1);
                bytes_left_next = length - 16'd1;
            end
        end
        else
        begin
            q_cmd.kind      = CMD_DATA;
            q_cmd.last      = (bytes_left_reg == 16'd1);
            bytes_left_next = bytes_left_reg - 16'd1;
        end
    end

    // Frame tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 16'd0;
        end
        else if (accept)
        begin
            bytes_left_reg <= bytes_left_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (cfg_wr_en)
        begin
            max_payload_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

### hdl/cfpe_fifo.sv
// ----------------------------------------------------------------------------
// cfpe_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cfpe_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire cfpe_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output cfpe_pkg::cmd_t     head_cmd
);
    import cfpe_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `CFPE_NEVER(a_no_push_full, clk, rst_n, push && full)
    `CFPE_NEVER(a_no_pop_empty, clk, rst_n, pop && !head_valid)
    `CFPE_ASSERT(a_empty_ptrs, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

`default_nettype wire

### hdl/cfpe_back.sv
// ----------------------------------------------------------------------------
// cfpe_back
// Expands queued commands into the framed byte stream and runs the CRC.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cfpe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire cfpe_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               error
);
    import cfpe_pkg::*;

    logic [3:0]  step_reg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg;
    logic        error_reg;

    logic        fire;
    logic        done;
    logic [3:0]  idx;
    logic [7:0]  byte_sel;
    logic [31:0] crc_fin;

    assign fire    = head_valid && (!out_valid_reg || out_ready);
    assign pop     = fire && done;
    assign crc_fin = ~crc_reg;

    // Position in the frame; continuation bytes start at the payload slot
    assign idx = (head_cmd.kind == CMD_DATA) ? (IDX_DATA + step_reg) : step_reg;

    // Byte for this position
    always_comb
    begin
        case (idx)
            IDX_CHAN: byte_sel = head_cmd.chan;
            IDX_SEQ0: byte_sel = head_cmd.seq[31:24];
            IDX_SEQ1: byte_sel = head_cmd.seq[23:16];
            IDX_SEQ2: byte_sel = head_cmd.seq[15:8];
            IDX_SEQ3: byte_sel = head_cmd.seq[7:0];
            IDX_LEN0: byte_sel = head_cmd.len[15:8];
            IDX_LEN1: byte_sel = head_cmd.len[7:0];
            IDX_DATA: byte_sel = head_cmd.data;
            IDX_CRC0: byte_sel = crc_fin[31:24];
            IDX_CRC1: byte_sel = crc_fin[23:16];
            IDX_CRC2: byte_sel = crc_fin[15:8];
            IDX_CRC3: byte_sel = crc_fin[7:0];
            default:  byte_sel = magic_byte(idx[1:0]);
        endcase
    end

    // CRC advance: restart at the first magic byte, hold over the CRC bytes
    always_comb
    begin
        if (idx == IDX_MAGIC0)
        begin
            crc_next = crc_feed(CRC_INIT, byte_sel);
        end
        else if (idx <= IDX_DATA)
        begin
            crc_next = crc_feed(crc_reg, byte_sel);
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    // End of the current command
    always_comb
    begin
        case (head_cmd.kind)
            CMD_ERR: done = 1'b1;
            default: done = (idx == IDX_CRC3) || ((idx == IDX_DATA) && !head_cmd.last);
        endcase
    end

    // Sequencer and CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            crc_reg  <= CRC_INIT;
        end
        else if (fire)
        begin
            step_reg <= done ? 4'd0 : (step_reg + 4'd1);
            if (head_cmd.kind != CMD_ERR)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (head_cmd.kind == CMD_ERR)
            begin
                out_byte_reg <= 8'd0;
                last_reg     <= 1'b0;
                error_reg    <= 1'b1;
            end
            else
            begin
                out_byte_reg <= byte_sel;
                last_reg     <= (idx == IDX_CRC3);
                error_reg    <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    `CFPE_ASSERT(a_err_clean, clk, rst_n, (out_valid_reg && error_reg) |-> (out_byte_reg == 8'd0 && !last_reg))
    `CFPE_NEVER(a_data_step, clk, rst_n, head_valid && (head_cmd.kind == CMD_DATA) && (step_reg > 4'd4))
    `CFPE_NEVER(a_err_step, clk, rst_n, head_valid && (head_cmd.kind == CMD_ERR) && (step_reg != 4'd0))
    `CFPE_ASSERT(a_pop_step, clk, rst_n, pop |=> (step_reg == 4'd0))

endmodule

`default_nettype wire

### hdl/crc_framed_packet_encoder_top.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_encoder_top
// Framed packet encoder: header, payload and CRC-32 on a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one payload byte per item with
//   the frame's channel, sequence_req and length; the header fields are used
//   only on the first byte of a frame. Output channel (out_valid/out_ready)
//   carries one framed byte per item with last and error flags.
//   cfg_wr_en/cfg_wr_data load max_payload; write only when idle.
// Path: an accepted item is written into the command queue; with the queue
//   empty, the back end takes it from there into the output register.
// Throughput: with out_ready high and a command queued, the output side
//   moves one byte per cycle. A frame of N payload bytes gives N+15 output
//   bytes; a refused header gives one. The 4-entry command queue takes
//   items at one per cycle while the back end is busy with header and CRC
//   bytes; in_ready drops only when the queue is full.
// Reset: queue empty, between frames, CRC all ones, max_payload 1024.
// Stall: with out_ready low the output byte holds, the back end waits and the
//   queue fills, after which in_ready goes low; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_packet_encoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  channel,
    input  wire logic [31:0] sequence_req,
    input  wire logic [15:0] length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             error
);
    import cfpe_pkg::*;

    cmd_t q_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic head_valid;

    cfpe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .channel      (channel),
        .sequence_req (sequence_req),
        .length       (length),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    cfpe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    cfpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error)
    );

endmodule

`default_nettype wire
